// File: hdl/vector3_normalize_defines.svh
// Assertion macros for the vector3_normalize block.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef VECTOR3_NORMALIZE_DEFINES_SVH
`define VECTOR3_NORMALIZE_DEFINES_SVH
`ifndef SYNTH
// Clocked check, switched off while reset is high
`define VN_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("vector3_normalize check failed");
// Clocked check that also holds during reset
`define VN_ASSERT_ALWAYS(name, clk, prop) \
   name: assert property (@(posedge clk) prop) \
      else $error("vector3_normalize check failed");
`else
`define VN_ASSERT(name, clk, rst, prop)
`define VN_ASSERT_ALWAYS(name, clk, prop)
`endif
`endif

// File: hdl/vn_pkg.sv
// Shared constants and types for the vector normaliser.
// No dependencies.
`default_nettype none
package vn_pkg;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] REG_ZERO_THRESHOLD = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_UNIT_TOLERANCE = 2'd1;

   typedef enum logic [1:0] {
      PATH_NORM = 2'd0,
      PATH_ZERO = 2'd1,
      PATH_UNIT = 2'd2
   } path_type;
endpackage
`default_nettype wire

// File: hdl/vn_ifs.sv
// Valid/ready channel interfaces for the vector normaliser.
// No dependencies.
`default_nettype none
interface vn_req_if #(parameter int CW = 16);
   logic                 valid;
   logic                 ready;
   logic signed [CW-1:0] in_x;
   logic signed [CW-1:0] in_y;
   logic signed [CW-1:0] in_z;
   modport source (output valid, output in_x, output in_y, output in_z, input ready);
   modport sink (input valid, input in_x, input in_y, input in_z, output ready);
endinterface

interface vn_rsp_if #(parameter int CW = 16);
   logic                 valid;
   logic                 ready;
   logic signed [CW-1:0] out_x;
   logic signed [CW-1:0] out_y;
   logic signed [CW-1:0] out_z;
   logic [1:0]           path_taken;
   modport source (output valid, output out_x, output out_y, output out_z,
                   output path_taken, input ready);
   modport sink (input valid, input out_x, input out_y, input out_z,
                 input path_taken, output ready);
endinterface
`default_nettype wire

// File: hdl/vn_sqrt.sv
// Pipelined integer square root, one root bit per stage.
// Standalone; no package needed.
`default_nettype none
module vn_sqrt #(
   parameter int CW = 16
) (
   input  logic            clock,
   input  logic            enable,
   input  logic [2*CW-1:0] radicand,
   output logic [CW-1:0]   root
);
   localparam int SW = 2 * CW;
   localparam int RW = CW;

   logic [SW-1:0] rem_ff  [RW];
   logic [RW-1:0] root_ff [RW];

   for (genvar j = 0; j < RW; j++) begin : g_stage
      localparam int B = RW - 1 - j;
      logic [SW-1:0] rem_i;
      logic [RW-1:0] root_i;
      logic [SW-1:0] trial;
      logic          take;

      if (j == 0) begin : g_first
         assign rem_i  = radicand;
         assign root_i = '0;
      end else begin : g_next
         assign rem_i  = rem_ff[j-1];
         assign root_i = root_ff[j-1];
      end

      // (root + 2^B)^2 - root^2
      assign trial = (SW'(root_i) << (B + 1)) | (SW'(1) << (2 * B));
      assign take  = rem_i >= trial;

      always_ff @(posedge clock) begin
         if (enable) begin
            rem_ff[j]  <= take ? rem_i - trial : rem_i;
            root_ff[j] <= take ? (root_i | (RW'(1) << B)) : root_i;
         end
      end
   end

   assign root = root_ff[RW-1];
endmodule
`default_nettype wire

// File: hdl/vn_div.sv
// Pipelined restoring divider lane: (|c| << FB) / len, signed and saturated.
// Standalone; no package needed.
`default_nettype none
module vn_div #(
   parameter int CW = 16,
   parameter int FB = 14
) (
   input  logic          clock,
   input  logic          enable,
   input  logic [CW-1:0] dividend,
   input  logic [CW-1:0] divisor,
   output logic [CW-1:0] quotient
);
   localparam int DW = CW + FB;
   localparam logic [DW-1:0] QMAX = DW'({1'b0, {(CW-1){1'b1}}});
   localparam logic [DW-1:0] QMIN = QMAX + DW'(1);

   logic [CW-1:0] mag0;
   logic [CW-1:0] rem_ff [DW];
   logic [DW-1:0] dq_ff  [DW];
   logic [CW-1:0] dvs_ff [DW];
   logic          neg_ff [DW];

   assign mag0 = dividend[CW-1] ? CW'(-dividend) : dividend;

   for (genvar j = 0; j < DW; j++) begin : g_stage
      logic [CW-1:0] rem_i;
      logic [DW-1:0] dq_i;
      logic [CW-1:0] dvs_i;
      logic          neg_i;
      logic [CW:0]   rn;
      logic          take;

      if (j == 0) begin : g_first
         assign rem_i = '0;
         assign dq_i  = {mag0, {FB{1'b0}}};
         assign dvs_i = divisor;
         assign neg_i = dividend[CW-1];
      end else begin : g_next
         assign rem_i = rem_ff[j-1];
         assign dq_i  = dq_ff[j-1];
         assign dvs_i = dvs_ff[j-1];
         assign neg_i = neg_ff[j-1];
      end

      assign rn   = {rem_i, dq_i[DW-1]};
      assign take = rn >= {1'b0, dvs_i};

      always_ff @(posedge clock) begin
         if (enable) begin
            rem_ff[j] <= take ? CW'(rn - {1'b0, dvs_i}) : CW'(rn);
            dq_ff[j]  <= {dq_i[DW-2:0], take};
            dvs_ff[j] <= dvs_i;
            neg_ff[j] <= neg_i;
         end
      end
   end

   // saturate to the signed component range
   always_comb begin
      if (neg_ff[DW-1]) begin
         quotient = (dq_ff[DW-1] > QMIN) ? {1'b1, {(CW-1){1'b0}}}
                                         : CW'(-dq_ff[DW-1][CW-1:0]);
      end else begin
         quotient = (dq_ff[DW-1] > QMAX) ? {1'b0, {(CW-1){1'b1}}}
                                         : dq_ff[DW-1][CW-1:0];
      end
   end
endmodule
`default_nettype wire

// File: hdl/vector3_normalize.sv
// Stages from accepted word to result: squares, sum, one stage per root bit, length check,
// one per quotient bit, output.
// Throughput: one word per cycle; the whole pipe holds while the output word is stalled.
// Reset: synchronous, active high; clears stage valids and both thresholds to zero.
// Depends on vn_pkg, vn_ifs, vn_sqrt, vn_div and vector3_normalize_defines.svh.
`default_nettype none
`include "vector3_normalize_defines.svh"
module vector3_normalize #(
   parameter int COMPONENT_WIDTH = 16,
   parameter int FRACTION_BITS   = 14
) (
   input  logic                          clock,
   input  logic                          reset,
   vn_req_if.sink                        req_ch,
   vn_rsp_if.source                      rsp_ch,
   input  logic                          csr_we,
   input  logic [vn_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [vn_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import vn_pkg::*;

   localparam int CW  = COMPONENT_WIDTH;
   localparam int FB  = FRACTION_BITS;
   localparam int SW  = 2 * CW;       // squared length
   localparam int RW  = CW;           // root
   localparam int DW  = CW + FB;      // quotient bits
   localparam int NST = RW + DW + 4;  // total stages incl. output register

   // side data that travels alongside the root and divider pipes
   typedef struct packed {
      logic [2:0][CW-1:0] c;
      logic               zero;   // squared length within zero threshold
      logic               unit;   // squared length within tolerance of one
      logic               lenz;   // root within zero threshold
   } side_type;

   // ---- configuration registers ----
   logic [CSR_DATA_W-1:0] zero_thr_ff, unit_tol_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         zero_thr_ff <= '0;
         unit_tol_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            REG_ZERO_THRESHOLD: zero_thr_ff <= csr_wdata;
            REG_UNIT_TOLERANCE: unit_tol_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // ---- flow control: one enable for every stage ----
   logic           adv;
   logic [NST-1:0] vld_ff, vld_in;

   assign adv          = !rsp_ch.valid || rsp_ch.ready;
   assign req_ch.ready = adv;
   assign vld_in       = {vld_ff[NST-2:0], req_ch.valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   // ---- stage 1: per-lane magnitude and square ----
   logic [CW-1:0] c0 [3];
   logic [CW-1:0] c1_ff [3];
   logic [SW-1:0] sq1_ff [3];

   assign c0[0] = req_ch.in_x;
   assign c0[1] = req_ch.in_y;
   assign c0[2] = req_ch.in_z;

   for (genvar g = 0; g < 3; g++) begin : g_sq
      logic [CW-1:0] m;
      assign m = c0[g][CW-1] ? CW'(-c0[g]) : c0[g];
      always_ff @(posedge clock) begin
         if (adv) begin
            c1_ff[g]  <= c0[g];
            sq1_ff[g] <= SW'(m) * SW'(m);
         end
      end
   end

   // ---- stage 2: sum of squares ----
   logic [CW-1:0] c2_ff [3];
   logic [SW-1:0] s2_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         c2_ff <= c1_ff;
         s2_ff <= sq1_ff[0] + sq1_ff[1] + sq1_ff[2];
      end
   end

   // threshold tests on the squared length truncated to FB fraction bits
   logic [SW-1:0] sq_w, one_w, diff_w;
   logic          zero_f, unit_f;

   assign sq_w   = s2_ff >> FB;
   assign one_w  = SW'(1) << FB;
   assign diff_w = (sq_w >= one_w) ? sq_w - one_w : one_w - sq_w;
   assign zero_f = sq_w <= SW'(zero_thr_ff);
   assign unit_f = diff_w <= SW'(unit_tol_ff);

   // ---- root pipe, side data delayed to match ----
   logic [RW-1:0] root;
   side_type      sd1_ff [RW];

   vn_sqrt #(.CW(CW)) u_sqrt (
      .clock    (clock),
      .enable   (adv),
      .radicand (s2_ff),
      .root     (root)
   );

   for (genvar k = 0; k < RW; k++) begin : g_sd1
      always_ff @(posedge clock) begin
         if (adv) begin
            if (k == 0) begin
               sd1_ff[k] <= '{c: {c2_ff[2], c2_ff[1], c2_ff[0]},
                              zero: zero_f, unit: unit_f, lenz: 1'b0};
            end else begin
               sd1_ff[k] <= sd1_ff[(k == 0) ? 0 : k-1];
            end
         end
      end
   end

   // ---- length stage: root against zero threshold ----
   logic [RW-1:0] root3_ff;
   side_type      sd3_ff, sd3_in;

   always_comb begin
      sd3_in      = sd1_ff[RW-1];
      sd3_in.lenz = SW'(root) <= SW'(zero_thr_ff);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         root3_ff <= root;
         sd3_ff   <= sd3_in;
      end
   end

   // ---- divider lanes ----
   logic [CW-1:0] q_lane [3];
   side_type      sd4_ff [DW];

   for (genvar g = 0; g < 3; g++) begin : g_div
      vn_div #(.CW(CW), .FB(FB)) u_div (
         .clock    (clock),
         .enable   (adv),
         .dividend (sd3_ff.c[g]),
         .divisor  (root3_ff),
         .quotient (q_lane[g])
      );
   end

   for (genvar k = 0; k < DW; k++) begin : g_sd4
      always_ff @(posedge clock) begin
         if (adv) begin
            if (k == 0) begin
               sd4_ff[k] <= sd3_ff;
            end else begin
               sd4_ff[k] <= sd4_ff[(k == 0) ? 0 : k-1];
            end
         end
      end
   end

   // ---- merge: pick the path and register the result word ----
   side_type      sdm;
   path_type      path_in;
   logic [CW-1:0] out_in [3];
   logic [CW-1:0] out_ff [3];
   path_type      path_ff;

   assign sdm = sd4_ff[DW-1];

   always_comb begin
      if (sdm.zero) begin
         path_in = PATH_ZERO;
      end else if (sdm.unit) begin
         path_in = PATH_UNIT;
      end else if (sdm.lenz) begin
         path_in = PATH_ZERO;
      end else begin
         path_in = PATH_NORM;
      end
      for (int g = 0; g < 3; g++) begin
         out_in[g] = (path_in == PATH_NORM) ? q_lane[g] : sdm.c[g];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_ff  <= out_in;
         path_ff <= path_in;
      end
   end

   assign rsp_ch.valid      = vld_ff[NST-1];
   assign rsp_ch.out_x      = out_ff[0];
   assign rsp_ch.out_y      = out_ff[1];
   assign rsp_ch.out_z      = out_ff[2];
   assign rsp_ch.path_taken = path_ff;

   // ---- checks ----
   `VN_ASSERT(a_accept_enters, clock, reset, req_ch.valid && req_ch.ready |=> vld_ff[0])
   `VN_ASSERT(a_stall_holds, clock, reset, !adv |=> $stable(vld_ff))
   `VN_ASSERT(a_div_nonzero, clock, reset, vld_ff[RW+2] && !sd3_ff.zero && !sd3_ff.unit && !sd3_ff.lenz |-> root3_ff != '0)
   `VN_ASSERT(a_path_code, clock, reset, rsp_ch.valid |-> rsp_ch.path_taken != 2'd3)
endmodule
`default_nettype wire
